// ----- rtl/core/sxe_pkg.sv -----
package sxe_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int CFG_W  = 12;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } sxe_reg_t;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] FRAME_MIN          = 12'd3;

  // one column of the 3-row neighborhood
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } sxe_column_t;

  typedef struct packed {
    logic             frame_last;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [PIX_W-1:0] edge_value;
  } sxe_result_t;

  // weighted column sum of the kernel: 1, 2, 1
  function automatic logic [PIX_W+1:0] column_sum(sxe_column_t c);
    return {2'b00, c.top} + {1'b0, c.mid, 1'b0} + {2'b00, c.bot};
  endfunction

  // right column minus left column, clamped to 0..255
  function automatic logic [PIX_W-1:0] gradient_clamp(sxe_column_t left, sxe_column_t right);
    logic signed [PIX_W+2:0] diff;
    diff = $signed({1'b0, column_sum(right)}) - $signed({1'b0, column_sum(left)});
    if (diff < 0) begin
      return '0;
    end else if (diff > $signed({3'b000, {PIX_W{1'b1}}})) begin
      return {PIX_W{1'b1}};
    end else begin
      return diff[PIX_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/sxe_line_store.sv -----
module sxe_line_store import sxe_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [2*PIX_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [2*PIX_W-1:0] rd_data
);

  // upper row in the high byte, middle row in the low byte
  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/sxe_column_cell.sv -----
module sxe_column_cell import sxe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  sxe_column_t col_in,
  output sxe_column_t col_out
);

  // take the neighbor's column on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (advance) begin
      col_out <= col_in;
    end
  end

endmodule

// ----- rtl/core/sxe_out_skid.sv -----
module sxe_out_skid import sxe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  sxe_result_t push_data,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output sxe_result_t out_data
);

  logic        skid_valid;
  sxe_result_t skid_data;

  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- rtl/core/sobel_x_edge_stream.sv -----
// Horizontal 3x3 Sobel filter on a raster-order 8-bit grayscale stream. Feed one
// pixel per word on the slave side, row by row, for a frame of frame_width by
// frame_height pixels (width saturates to 3..MAX_WIDTH, height to at least 3).
// Every interior pixel gives one master word: the gradient clamped to 0..255 with
// its row and column; border pixels give none, and the final interior pixel of
// the frame carries tlast. The block takes one pixel every clock while the output
// stage has room; that rate is set by the line store, whose single read port fetches
// the next column's two stored rows in the same cycle that the current pixel is
// accepted. A two-word output stage keeps the input moving while one result waits.
// The line store is not cleared after reset; it needs no clearing pass, since
// every entry is written before a result depends on it.
// Write frame_width and frame_height only while no word is in flight. A change
// mid-frame keeps the position counts; a count at or past the new end of row or
// frame wraps on the next pixel. Do not widen the row mid-frame.
module sobel_x_edge_stream import sxe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // pixel input
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] pixel_in
  // gradient output
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] edge_value, [19:8] out_row,
                                           // [30:20] out_col, [31] zero
  output logic             m_axis_tlast    // frame_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (MW > CFG_W) ? MW : CFG_W;
  localparam logic [CW-1:0] MAX_W = CW'(MAX_WIDTH);

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (sxe_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [CW-1:0]    width_eff;
  logic [CFG_W-1:0] height_eff;

  always_comb begin
    width_eff = CW'(frame_width);
    if (width_eff < CW'(FRAME_MIN)) width_eff = CW'(FRAME_MIN);
    if (width_eff > MAX_W)          width_eff = MAX_W;
    height_eff = (frame_height < FRAME_MIN) ? FRAME_MIN : frame_height;
  end

  // position counters
  logic [COL_W-1:0] col_count, col_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             accept;
  logic             row_end;
  logic             frame_end;
  logic             emit;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign row_end   = CW'(col_count) >= (width_eff - CW'(1));
  assign frame_end = row_end && (row_count >= (height_eff - CFG_W'(1)));
  assign emit      = (col_count >= COL_W'(2)) && (row_count >= ROW_W'(2));

  always_comb begin
    col_count_next = col_count + COL_W'(1);
    row_count_next = row_count;
    if (row_end) begin
      col_count_next = '0;
      row_count_next = frame_end ? '0 : row_count + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line store address: a column beyond the store folds to entry zero
  function automatic logic [AW-1:0] store_addr(logic [COL_W-1:0] c);
    return (CW'(c) < MAX_W) ? AW'(c) : '0;
  endfunction

  // read the next column's stored rows while the current word is taken
  logic [2*PIX_W-1:0] store_rd;
  sxe_column_t        cur_col;

  assign cur_col.top = store_rd[2*PIX_W-1:PIX_W];
  assign cur_col.mid = store_rd[PIX_W-1:0];
  assign cur_col.bot = s_axis_tdata[PIX_W-1:0];

  sxe_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(store_addr(col_count)),
    .wr_data({cur_col.mid, cur_col.bot}),
    .rd_en  (accept),
    .rd_addr(store_addr(col_count_next)),
    .rd_data(store_rd)
  );

  // window: a chain of two column cells, c-1 then c-2
  sxe_column_t prev1_col;
  sxe_column_t prev2_col;

  sxe_column_cell u_cell_c1 (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .col_in (cur_col),
    .col_out(prev1_col)
  );

  sxe_column_cell u_cell_c2 (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .col_in (prev1_col),
    .col_out(prev2_col)
  );

  // result for the pixel one row up and one column left
  sxe_result_t result;
  sxe_result_t out_res;
  logic        room;

  assign result.edge_value = gradient_clamp(prev2_col, cur_col);
  assign result.out_row    = row_count - ROW_W'(1);
  assign result.out_col    = col_count - COL_W'(1);
  assign result.frame_last = frame_end;

  sxe_out_skid u_out_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && emit),
    .push_data(result),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_res)
  );

  assign s_axis_tready = room;
  assign m_axis_tdata  = {1'b0, out_res.out_col, out_res.out_row, out_res.edge_value};
  assign m_axis_tlast  = out_res.frame_last;

  // a shown result never belongs to the first row or the first column
  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.out_row != '0) && (out_res.out_col != '0))
    else $error("result word for a border pixel");

  // input stalls only while a result is waiting
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output stage");

  // column wraps to zero after the end of a row
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && row_end) |=> (col_count == '0))
    else $error("column count did not wrap at end of row");

endmodule

// ----- verif/sobel_x_edge_stream_tb.sv -----
module sobel_x_edge_stream_tb;
  import sxe_pkg::*;

  localparam int MAX_W = MAX_WIDTH;
  localparam int RANDOM_PIXELS = 550;
  localparam int SHOW_LIMIT = 20;
  localparam sxe_result_t NO_RESULT = '0;

  // receiver stall patterns
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  // one row of the directed plan: a register write or a pixel with its known outcome
  typedef struct packed {
    logic        is_cfg;
    sxe_reg_t    sel;
    logic [11:0] value;
    logic [7:0]  px;
    logic        has_result;
    sxe_result_t res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;    // [7:0] pixel_in
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] edge_value, [19:8] out_row, [30:20] out_col
  logic m_axis_tlast;               // frame_last

  sobel_x_edge_stream i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #5 clk = ~clk;

  // gradient predictor state
  logic [7:0] upper_row [MAX_W];
  logic [7:0] middle_row [MAX_W];
  sxe_column_t older_col, newer_col;
  int col_at, row_at;
  logic [11:0] width_reg, height_reg;
  bit frame_closed;

  sxe_result_t edge_expected [$];
  plan_row_t plan [20];

  int errors = 0;
  int pixels_in = 0;
  int words_checked = 0;
  int frames_seen = 0;
  int burst_left = 0;
  int max_gap = 5;
  bit hold_off = 1'b0;
  bit pressure_arm = 1'b0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= SHOW_LIMIT)
      $display("mismatch %0d at %0t: %s got %0d want %0d", errors, $time, what, got, want);
  endtask

  // advance the filter by one pixel; emit the gradient of the pixel above-left
  task automatic sobel_advance(input logic [7:0] px, output bit emitted,
                               output sxe_result_t res, output bit frame_end);
    int w, h, right, left, grad;
    sxe_column_t cur;
    bit row_end;
    w = (width_reg < FRAME_MIN) ? 3 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
    h = (height_reg < FRAME_MIN) ? 3 : int'(height_reg);
    cur.top = upper_row[col_at];
    cur.mid = middle_row[col_at];
    cur.bot = px;
    row_end = (col_at >= w - 1);
    frame_end = row_end && (row_at >= h - 1);
    emitted = (col_at >= 2) && (row_at >= 2);
    res = '0;
    if (emitted) begin
      right = cur.top + 2 * cur.mid + cur.bot;
      left = older_col.top + 2 * older_col.mid + older_col.bot;
      grad = right - left;
      if (grad < 0) grad = 0;
      else if (grad > 255) grad = 255;
      res.edge_value = grad[7:0];
      res.out_row = 12'(row_at - 1);
      res.out_col = 11'(col_at - 1);
      res.frame_last = frame_end;
    end
    older_col = newer_col;
    newer_col = cur;
    upper_row[col_at] = cur.mid;
    middle_row[col_at] = px;
    if (row_end) begin
      col_at = 0;
      row_at = frame_end ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one pixel word, with a random gap at the start of each burst
  task automatic offer_pixel(input logic [7:0] px, input bit typed, input bit typed_has,
                             input sxe_result_t typed_res);
    int gap;
    bit emitted, fend;
    sxe_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk) s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk); while (!s_axis_tready);
    pixels_in++;
    sobel_advance(px, emitted, res, fend);
    frame_closed = fend;
    if (fend) frames_seen++;
    if (typed) begin
      if (typed_has) edge_expected.push_back(typed_res);
    end else if (emitted) begin
      edge_expected.push_back(res);
    end
  endtask

  task automatic feed_count(input int n);
    repeat (n) offer_pixel(rand_pixel(), 1'b0, 1'b0, NO_RESULT);
  endtask

  task automatic feed_to_frame_end();
    do offer_pixel(rand_pixel(), 1'b0, 1'b0, NO_RESULT); while (!frame_closed);
  endtask

  // drop valid, wait for every expected word, then let the pipeline empty
  task automatic drain_block();
    int guard;
    guard = 0;
    @(negedge clk) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (edge_expected.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (edge_expected.size() != 0) begin
      flag_mismatch("words never delivered", 0, edge_expected.size());
      edge_expected.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input sxe_reg_t sel, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    if (sel == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // receiver: switch between random stall patterns, hold off on request
  rx_pattern_t rx_mode = RX_ALWAYS;
  int rx_left = 0;
  int rx_tick = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_tick++;
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_tick % 5 != 0);
      endcase
    end
  end

  // long receiver hold-off while the sender keeps offering pixels
  initial begin
    wait (pressure_arm);
    repeat (100) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // compare each gradient word with the oldest expectation
  sxe_result_t want;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (edge_expected.size() == 0) begin
        flag_mismatch("word with nothing expected, tdata", int'(m_axis_tdata), 0);
      end else begin
        want = edge_expected.pop_front();
        words_checked++;
        if (m_axis_tdata[7:0] != want.edge_value)
          flag_mismatch("edge_value", int'(m_axis_tdata[7:0]), int'(want.edge_value));
        if (m_axis_tdata[19:8] != want.out_row)
          flag_mismatch("out_row", int'(m_axis_tdata[19:8]), int'(want.out_row));
        if (m_axis_tdata[30:20] != want.out_col)
          flag_mismatch("out_col", int'(m_axis_tdata[30:20]), int'(want.out_col));
        if (m_axis_tlast !== want.frame_last)
          flag_mismatch("frame_last", int'(m_axis_tlast), int'(want.frame_last));
        if (m_axis_tdata[31] !== 1'b0)
          flag_mismatch("padding bit 31", int'(m_axis_tdata[31]), 0);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("** sobel_x_edge_stream: FAILED **");
    $finish;
  end

  initial begin
    int w, h, eff_w, eff_h, start_px;
    // 3x3 frames: left column dark and right bright clamps high, the mirror clamps low
    plan[0]  = '{1'b1, REG_FRAME_WIDTH,  12'd3, 8'h00, 1'b0, NO_RESULT};
    plan[1]  = '{1'b1, REG_FRAME_HEIGHT, 12'd3, 8'h00, 1'b0, NO_RESULT};
    plan[2]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, NO_RESULT};
    plan[3]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h55, 1'b0, NO_RESULT};
    plan[4]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'hff, 1'b0, NO_RESULT};
    plan[5]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, NO_RESULT};
    plan[6]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'haa, 1'b0, NO_RESULT};
    plan[7]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'hff, 1'b0, NO_RESULT};
    plan[8]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, NO_RESULT};
    plan[9]  = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h55, 1'b0, NO_RESULT};
    plan[10] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'hff, 1'b1,
                 '{1'b1, 11'd1, 12'd1, 8'd255}};
    plan[11] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'hff, 1'b0, NO_RESULT};
    plan[12] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'haa, 1'b0, NO_RESULT};
    plan[13] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, NO_RESULT};
    plan[14] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'hff, 1'b0, NO_RESULT};
    plan[15] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h55, 1'b0, NO_RESULT};
    plan[16] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, NO_RESULT};
    plan[17] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'hff, 1'b0, NO_RESULT};
    plan[18] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'haa, 1'b0, NO_RESULT};
    plan[19] = '{1'b0, REG_FRAME_WIDTH,  12'd0, 8'h00, 1'b1,
                 '{1'b1, 11'd1, 12'd1, 8'd0}};

    width_reg = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    older_col = '0;
    newer_col = '0;
    col_at = 0;
    row_at = 0;
    frame_closed = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset width: one full row plus a few pixels, then shrink to close the frame
    feed_count(640 + 5);
    drain_block();
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    write_reg(REG_FRAME_WIDTH, 12'd3);
    feed_to_frame_end();

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_block();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        offer_pixel(plan[i].px, 1'b1, plan[i].has_result, plan[i].res);
      end
    end

    // random small frames, some with out-of-range sizes, some shrunk mid-frame
    pressure_arm = 1'b1;
    start_px = pixels_in;
    while (pixels_in - start_px < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      eff_w = (w < 3) ? 3 : w;
      eff_h = (h < 3) ? 3 : h;
      drain_block();
      write_reg(REG_FRAME_WIDTH, 12'(w));
      write_reg(REG_FRAME_HEIGHT, 12'(h));
      if ($urandom_range(0, 4) == 0) begin
        // shrink only: a wider row would read line store entries never written
        feed_count($urandom_range(1, eff_w * eff_h - 1));
        drain_block();
        write_reg(REG_FRAME_WIDTH, 12'($urandom_range(0, eff_w)));
        if ($urandom_range(0, 1) == 1) write_reg(REG_FRAME_HEIGHT, 12'($urandom_range(0, 8)));
      end
      feed_to_frame_end();
    end

    // tallest height register: fifteen rows, then cut the frame short
    drain_block();
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd4095);
    feed_count(45);
    drain_block();
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    feed_to_frame_end();
    // width register past the store depth, shrunk early in the first row
    drain_block();
    write_reg(REG_FRAME_WIDTH, 12'd4095);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    feed_count(20);
    drain_block();
    write_reg(REG_FRAME_WIDTH, 12'd5);
    feed_to_frame_end();

    drain_block();
    $display("sobel_x_edge_stream: %0d pixels in, %0d gradient words checked, %0d frames",
             pixels_in, words_checked, frames_seen);
    $display("reset width, clamped 3x3 frames, small random frames, saturated registers,");
    $display("mid-frame shrinks and a long receiver hold-off");
    if (errors == 0) begin
      $display("** sobel_x_edge_stream: PASSED **");
    end else begin
      $display("** sobel_x_edge_stream: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sobel_x_edge_stream.f -----
rtl/core/sxe_pkg.sv
rtl/core/sxe_line_store.sv
rtl/core/sxe_column_cell.sv
rtl/core/sxe_out_skid.sv
rtl/core/sobel_x_edge_stream.sv
verif/sobel_x_edge_stream_tb.sv
